### src/bru_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helpers of the bitplane record unpacker
package bru_pkg;

	localparam int MAX_PLANES = 32;
	localparam int MAX_SIDE   = 32;

	localparam int CFG_W   = 6;                      // width of a configuration register
	localparam int PLANE_W = $clog2(MAX_PLANES);     // plane index width
	localparam int POS_W   = 10;                     // position field width
	localparam int SQ_W    = 2 * $clog2(MAX_SIDE) + 1; // pixels per plane, up to MAX_SIDE squared
	localparam int LABEL_W = 31;
	localparam int NBITS_W = 4;                      // 1..8 results per queue entry
	localparam int QDEPTH  = 4;

	// result kinds
	localparam logic [1:0] KIND_PIXEL   = 2'd0;
	localparam logic [1:0] KIND_LABEL   = 2'd1;
	localparam logic [1:0] KIND_ALIGN   = 2'd2;
	localparam logic [1:0] KIND_NEG_LBL = 2'd3;

	// register indexes
	localparam logic CFG_NUM_PLANES = 1'b0;
	localparam logic CFG_IMAGE_SIDE = 1'b1;

	localparam logic [7:0] CHAR_G = 8'h47;
	localparam logic [7:0] CHAR_O = 8'h4F;
	localparam logic [7:0] PIX_ON = 8'd255;

	// clamped sizes seen by front and back
	typedef struct packed {
		logic [CFG_W-1:0] planes;
		logic [SQ_W-1:0]  sq;
	} bru_cfg_t;

	// one classified request waiting for the back end
	typedef struct packed {
		logic [1:0]         kind;
		logic [LABEL_W-1:0] data;    // pixel byte in the low bits, or the label
		logic [PLANE_W-1:0] plane;   // starting plane of a pixel byte
		logic [POS_W-1:0]   pos;     // starting position of a pixel byte
		logic [NBITS_W-1:0] nbits;   // results this entry yields
		logic               rec_end; // record ends on the final result
	} bru_entry_t;

	function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v,
			input logic [CFG_W-1:0] hi);
		logic [CFG_W-1:0] r;
		if (v == '0) r = CFG_W'(1);
		else if (v > hi) r = hi;
		else r = v;
		return r;
	endfunction

endpackage

### src/bitplane_record_unpacker_top.sv
`timescale 1ns / 1ps
// top level of the bitplane record unpacker: config registers, front, queue, back
//
// The unpacker takes one stream byte per request and turns records ('G', 'O',
// a 4-byte little-endian label, then planes x side x side pixel bits packed
// MSB first) into results: a label (or negative-label error), one pixel
// result per bit (0 or 255, tagged with plane and row-major position), and
// an alignment error on a bad marker, after which it hunts for the next 'G'.
// Marker and label bytes yield at most one result each; a pixel byte yields up
// to eight results and the result port delivers one per cycle while
// out_stall is low, so the single result register of the back end sets the
// pace in the pixel body. The front end frames the stream and works out,
// combinationally, where a record ends inside a pixel byte; a four-entry queue
// lets it keep taking bytes while the back end drains earlier ones, so
// in_stall rises only when that queue is full. Configuration registers are
// clamped on write (0 reads as 1, oversize as the maximum) and take effect
// for the next byte; write them only while no request is in flight.
module bitplane_record_unpacker_top (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration write port
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [bru_pkg::CFG_W-1:0]   cfg_wdata,
	// stream input
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  stream_byte,
	// results
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  kind,
	output logic [7:0]                  pixel,
	output logic [bru_pkg::PLANE_W-1:0] plane,
	output logic [bru_pkg::POS_W-1:0]   position,
	output logic [bru_pkg::LABEL_W-1:0] label,
	output logic                        last,
	output logic                        record_end
);
	import bru_pkg::*;

	bru_cfg_t         cfg_q;
	logic [CFG_W-1:0] side_clamped;
	bru_entry_t       push_data;
	bru_entry_t       head;
	logic             push;
	logic             pop;
	logic             not_empty;
	logic             full;

	assign side_clamped = clamp_cfg(cfg_wdata, CFG_W'(MAX_SIDE));
	assign in_stall     = full;

	// clamped sizes; the side is squared once here so the datapath only compares and subtracts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.planes <= CFG_W'(8);
			cfg_q.sq     <= SQ_W'(19 * 19);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NUM_PLANES: cfg_q.planes <= clamp_cfg(cfg_wdata, CFG_W'(MAX_PLANES));
				CFG_IMAGE_SIDE: cfg_q.sq <= SQ_W'(side_clamped) * SQ_W'(side_clamped);
				default: ;
			endcase
		end
	end

	// framing and classification of each stream byte
	bru_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.stream_byte (stream_byte),
		.full        (full),
		.push        (push),
		.push_data   (push_data)
	);

	// decouples byte intake from result delivery
	bru_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.full      (full)
	);

	// one result per cycle, while out_stall allows, into the output register
	bru_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head       (head),
		.not_empty  (not_empty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.pixel      (pixel),
		.plane      (plane),
		.position   (position),
		.label      (label),
		.last       (last),
		.record_end (record_end)
	);
endmodule

### src/bru_queue.sv
`timescale 1ns / 1ps
// small request queue between the front and the back end
module bru_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  bru_pkg::bru_entry_t push_data,
	input  logic                pop,
	output bru_pkg::bru_entry_t head,
	output logic                not_empty,
	output logic                full
);
	import bru_pkg::*;

	localparam int PTR_W = $clog2(QDEPTH);

	bru_entry_t       mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == (PTR_W+1)'(QDEPTH));
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push && !pop)      count_q <= count_q + (PTR_W+1)'(1);
			else if (pop && !push) count_q <= count_q - (PTR_W+1)'(1);
		end
	end
endmodule

### src/bru_front.sv
`timescale 1ns / 1ps
// front end: record framing, label assembly and pixel byte bookkeeping
module bru_front (
	input  logic                clk,
	input  logic                arst_n,
	input  bru_pkg::bru_cfg_t   cfg,
	input  logic                in_valid,
	input  logic [7:0]          stream_byte,
	input  logic                full,
	output logic                push,
	output bru_pkg::bru_entry_t push_data
);
	import bru_pkg::*;

	typedef enum logic [2:0] {
		PH_EXPECT_G,
		PH_HUNT,
		PH_EXPECT_O,
		PH_LABEL,
		PH_PIXELS
	} phase_t;

	phase_t             phase_q, phase_d;
	logic [23:0]        label_bytes_q, label_bytes_d;
	logic [1:0]         label_idx_q, label_idx_d;
	logic [PLANE_W-1:0] plane_q, plane_d;
	logic [POS_W-1:0]   pixel_q, pixel_d;
	logic               accept;
	logic               emit;

	assign accept = in_valid && !full;
	assign push   = accept && emit;

	always_comb begin : classify
		logic [SQ_W-1:0]    c_inc;
		logic [SQ_W-1:0]    gap;
		logic [3:0]         f;
		logic [3:0]         e;
		logic [3:0]         rest;
		logic [3:0]         wraps;
		logic [CFG_W-1:0]   need;
		logic               sq_one;
		logic               sq_four;
		logic [POS_W-1:0]   next_pos;
		logic [PLANE_W:0]   p;
		logic               done;
		logic [NBITS_W-1:0] nb;
		logic [31:0]        raw;
		phase_d       = phase_q;
		label_bytes_d = label_bytes_q;
		label_idx_d   = label_idx_q;
		plane_d       = plane_q;
		pixel_d       = pixel_q;
		emit          = 1'b0;
		push_data     = '0;
		push_data.nbits = NBITS_W'(1);
		raw  = {stream_byte, label_bytes_q};
		// first bit of the byte that closes a plane, 8 when none does
		c_inc = SQ_W'(pixel_q) + SQ_W'(1);
		gap   = cfg.sq - c_inc;
		if (c_inc >= cfg.sq) f = 4'd0;
		else if (gap <= SQ_W'(7)) f = gap[3:0];
		else f = 4'd8;
		// planes still to close after the first one before the record ends
		if (CFG_W'(plane_q) + CFG_W'(1) >= cfg.planes) need = '0;
		else need = cfg.planes - CFG_W'(plane_q) - CFG_W'(1);
		// sq is a square, so only 1 and 4 close a plane more than once per byte
		sq_one  = (cfg.sq == SQ_W'(1));
		sq_four = (cfg.sq == SQ_W'(4));
		rest    = 4'd7 - f;
		done    = 1'b0;
		e       = f;
		if (f != 4'd8) begin
			if (need == '0) begin
				done = 1'b1;
			end else if (sq_one && need <= CFG_W'(7)) begin
				done = 1'b1;
				e    = f + {1'b0, need[2:0]};
			end else if (sq_four && need == CFG_W'(1) && f <= 4'd3) begin
				done = 1'b1;
				e    = f + 4'd4;
			end
		end
		nb = done ? (NBITS_W'(e) + NBITS_W'(1)) : NBITS_W'(8);
		// counters after a byte that does not end the record
		if (f == 4'd8) begin
			wraps    = 4'd0;
			next_pos = pixel_q + POS_W'(8);
		end else if (sq_one) begin
			wraps    = 4'd8;
			next_pos = '0;
		end else if (sq_four) begin
			wraps    = 4'd1 + {2'b00, rest[3:2]};
			next_pos = POS_W'(rest[1:0]);
		end else begin
			wraps    = 4'd1;
			next_pos = POS_W'(rest);
		end
		p = (PLANE_W+1)'(plane_q) + (PLANE_W+1)'(wraps);
		case (phase_q)
			PH_EXPECT_G: begin
				if (stream_byte == CHAR_G) begin
					phase_d = PH_EXPECT_O;
				end else begin
					emit           = 1'b1;
					push_data.kind = KIND_ALIGN;
					phase_d        = PH_HUNT;
				end
			end
			PH_HUNT: begin
				if (stream_byte == CHAR_G) phase_d = PH_EXPECT_O;
			end
			PH_EXPECT_O: begin
				if (stream_byte == CHAR_O) begin
					phase_d       = PH_LABEL;
					label_idx_d   = '0;
					label_bytes_d = '0;
				end else begin
					emit           = 1'b1;
					push_data.kind = KIND_ALIGN;
					phase_d = (stream_byte == CHAR_G) ? PH_EXPECT_O : PH_HUNT;
				end
			end
			PH_LABEL: begin
				if (label_idx_q != 2'd3) begin
					// little endian: bytes shift in from the top
					label_bytes_d = {stream_byte, label_bytes_q[23:8]};
					label_idx_d   = label_idx_q + 2'd1;
				end else begin
					emit           = 1'b1;
					push_data.kind = raw[31] ? KIND_NEG_LBL : KIND_LABEL;
					push_data.data = raw[LABEL_W-1:0];
					label_idx_d    = '0;
					label_bytes_d  = '0;
					plane_d        = '0;
					pixel_d        = '0;
					phase_d        = PH_PIXELS;
				end
			end
			PH_PIXELS: begin
				emit              = 1'b1;
				push_data.kind    = KIND_PIXEL;
				push_data.data    = LABEL_W'(stream_byte);
				push_data.plane   = plane_q;
				push_data.pos     = pixel_q;
				push_data.nbits   = nb;
				push_data.rec_end = done;
				if (done) begin
					plane_d = '0;
					pixel_d = '0;
					phase_d = PH_EXPECT_G;
				end else begin
					plane_d = p[PLANE_W-1:0];
					pixel_d = next_pos;
				end
			end
			default: phase_d = PH_EXPECT_G;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_EXPECT_G;
			label_bytes_q <= '0;
			label_idx_q   <= '0;
			plane_q       <= '0;
			pixel_q       <= '0;
		end else if (accept) begin
			phase_q       <= phase_d;
			label_bytes_q <= label_bytes_d;
			label_idx_q   <= label_idx_d;
			plane_q       <= plane_d;
			pixel_q       <= pixel_d;
		end
	end
endmodule

### src/bru_back.sv
`timescale 1ns / 1ps
// back end: expands queued requests into results, one per cycle unless out_stall holds them
module bru_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  bru_pkg::bru_cfg_t       cfg,
	input  bru_pkg::bru_entry_t     head,
	input  logic                    not_empty,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [1:0]              kind,
	output logic [7:0]              pixel,
	output logic [bru_pkg::PLANE_W-1:0] plane,
	output logic [bru_pkg::POS_W-1:0]   position,
	output logic [bru_pkg::LABEL_W-1:0] label,
	output logic                    last,
	output logic                    record_end
);
	import bru_pkg::*;

	logic [2:0]         bit_q;
	logic [PLANE_W-1:0] run_plane_q;
	logic [POS_W-1:0]   run_pos_q;
	logic               valid_q;
	logic               load;
	logic               final_bit;
	logic [PLANE_W-1:0] cur_plane;
	logic [POS_W-1:0]   cur_pos;
	logic [SQ_W-1:0]    pos_inc;
	logic               is_pix;
	logic               bit_val;

	assign out_valid = valid_q;
	assign load      = not_empty && (!valid_q || !out_stall);
	assign final_bit = ({1'b0, bit_q} == (head.nbits - NBITS_W'(1)));
	assign pop       = load && final_bit;
	assign is_pix    = (head.kind == KIND_PIXEL);
	assign cur_plane = (bit_q == '0) ? head.plane : run_plane_q;
	assign cur_pos   = (bit_q == '0) ? head.pos : run_pos_q;
	assign pos_inc   = SQ_W'(cur_pos) + SQ_W'(1);
	assign bit_val   = head.data[3'd7 - bit_q];

	always_ff @(posedge clk) begin
		if (load) begin
			kind       <= head.kind;
			pixel      <= (is_pix && bit_val) ? PIX_ON : 8'd0;
			plane      <= is_pix ? cur_plane : '0;
			position   <= is_pix ? cur_pos : '0;
			label      <= is_pix ? '0 : head.data;
			last       <= final_bit;
			record_end <= final_bit && head.rec_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= 1'b0;
			bit_q       <= '0;
			run_plane_q <= '0;
			run_pos_q   <= '0;
		end else begin
			if (load) valid_q <= 1'b1;
			else if (!out_stall) valid_q <= 1'b0;
			if (load) begin
				bit_q <= final_bit ? 3'd0 : bit_q + 3'd1;
				// step the plane and position counters past this pixel
				if (pos_inc >= cfg.sq) begin
					run_pos_q   <= '0;
					run_plane_q <= cur_plane + PLANE_W'(1);
				end else begin
					run_pos_q   <= pos_inc[POS_W-1:0];
					run_plane_q <= cur_plane;
				end
			end
		end
	end
endmodule
